@@ design/rbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and codes for the 2D ray / box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    // face normal reported with a hit
    typedef enum logic [2:0] {
        NORM_NONE = 3'd0,
        NORM_PX   = 3'd1,
        NORM_NX   = 3'd2,
        NORM_PY   = 3'd3,
        NORM_NY   = 3'd4
    } norm_t;

endpackage

@@ design/ray_box_slab_intersect_top.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top
// 2D ray versus axis-aligned box slab test, fully pipelined.
// ----------------------------------------------------------------------------
// Start to done: stage 1, the bit-per-stage slab time dividers, then stages
//   P1 to P6, each registered.
// Throughput: one item per cycle; busy is always low.
// Results appear on done for one cycle; the receiver cannot stall.
// Reset: rst_n clears all valid bits and the side data delay line
//   asynchronously; the other data registers are not reset.
module ray_box_slab_intersect_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] box_min_x,
    input  logic signed [COORD_WIDTH-1:0] box_min_y,
    input  logic signed [COORD_WIDTH-1:0] box_max_x,
    input  logic signed [COORD_WIDTH-1:0] box_max_y,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] time_near,
    output logic signed [COORD_WIDTH-1:0] time_far,
    output logic signed [COORD_WIDTH-1:0] contact_x,
    output logic signed [COORD_WIDTH-1:0] contact_y,
    output logic [2:0]                    normal_code
);

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = CW + 1;            // slab numerator magnitude
    localparam int NW  = MW + FRAC_BITS;    // dividend / quotient width
    localparam int TW  = NW + 2;            // signed time incl. unbounded mark
    localparam int SBW = 4 * CW + 9;        // side data riding past the divider
    localparam int LAT = NW + 7;

    // unbounded slab ends lie beyond any finite quotient
    localparam logic signed [TW-1:0] T_UNB  = $signed({2'b01, {NW{1'b0}}});
    localparam logic signed [TW-1:0] T_NUNB = -T_UNB;
    localparam logic signed [TW-1:0] T_CMAX = TW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [TW-1:0] T_CMIN = -T_CMAX - TW'(1);

    assign busy = 1'b0;

    // ---------------- stage 1: slab numerators, signs, divisor magnitudes
    logic                 acc;
    logic signed [CW:0]   ox_e, oy_e, bx0_e, bx1_e, by0_e, by1_e;
    logic [MW-1:0]        nm00_next, nm01_next, nm10_next, nm11_next;
    logic [CW-1:0]        dmx_next, dmy_next;
    logic                 zx, zy, okx_next, oky_next;
    logic [3:0]           sg_next;
    logic [SBW-1:0]       sb_next;

    logic [MW-1:0]        nm00_reg, nm01_reg, nm10_reg, nm11_reg;
    logic [CW-1:0]        dmx_reg, dmy_reg;
    logic [SBW-1:0]       s1_reg;

    assign acc = start && !busy;

    always_comb
    begin
        ox_e  = {origin_x[CW-1], origin_x};
        oy_e  = {origin_y[CW-1], origin_y};
        bx0_e = {box_min_x[CW-1], box_min_x};
        bx1_e = {box_max_x[CW-1], box_max_x};
        by0_e = {box_min_y[CW-1], box_min_y};
        by1_e = {box_max_y[CW-1], box_max_y};
        // |bound - origin| without a second negate
        nm00_next = (box_min_x > origin_x) ? MW'(bx0_e - ox_e) : MW'(ox_e - bx0_e);
        nm01_next = (box_max_x > origin_x) ? MW'(bx1_e - ox_e) : MW'(ox_e - bx1_e);
        nm10_next = (box_min_y > origin_y) ? MW'(by0_e - oy_e) : MW'(oy_e - by0_e);
        nm11_next = (box_max_y > origin_y) ? MW'(by1_e - oy_e) : MW'(oy_e - by1_e);
        zx = (dir_x == '0);
        zy = (dir_y == '0);
        // zero divisor is replaced by one; those quotients are discarded
        dmx_next = zx ? CW'(1) : (dir_x[CW-1] ? (~dir_x + CW'(1)) : dir_x);
        dmy_next = zy ? CW'(1) : (dir_y[CW-1] ? (~dir_y + CW'(1)) : dir_y);
        // parallel ray: origin must be strictly inside the slab
        okx_next = !zx ||
                   (box_min_x < origin_x && origin_x < box_max_x) ||
                   (box_max_x < origin_x && origin_x < box_min_x);
        oky_next = !zy ||
                   (box_min_y < origin_y && origin_y < box_max_y) ||
                   (box_max_y < origin_y && origin_y < box_min_y);
        // quotient signs
        sg_next[0] = (origin_x > box_min_x) ^ dir_x[CW-1];
        sg_next[1] = (origin_x > box_max_x) ^ dir_x[CW-1];
        sg_next[2] = (origin_y > box_min_y) ^ dir_y[CW-1];
        sg_next[3] = (origin_y > box_max_y) ^ dir_y[CW-1];
        sb_next = {acc, zx, zy, okx_next, oky_next, sg_next,
                   origin_x, origin_y, dir_x, dir_y};
    end

    always_ff @(posedge clk)
    begin
        nm00_reg <= nm00_next;
        nm01_reg <= nm01_next;
        nm10_reg <= nm10_next;
        nm11_reg <= nm11_next;
        dmx_reg  <= dmx_next;
        dmy_reg  <= dmy_next;
    end

    // ---------------- slab time dividers
    logic [NW-1:0] q00, q01, q10, q11;

    rbsi_div #(.NW(NW), .DW(CW)) u_div00
    (
        .clk (clk),
        .num (NW'(nm00_reg) << FRAC_BITS),
        .den (dmx_reg),
        .quo (q00)
    );

    rbsi_div #(.NW(NW), .DW(CW)) u_div01
    (
        .clk (clk),
        .num (NW'(nm01_reg) << FRAC_BITS),
        .den (dmx_reg),
        .quo (q01)
    );

    rbsi_div #(.NW(NW), .DW(CW)) u_div10
    (
        .clk (clk),
        .num (NW'(nm10_reg) << FRAC_BITS),
        .den (dmy_reg),
        .quo (q10)
    );

    rbsi_div #(.NW(NW), .DW(CW)) u_div11
    (
        .clk (clk),
        .num (NW'(nm11_reg) << FRAC_BITS),
        .den (dmy_reg),
        .quo (q11)
    );

    // side data delay line, aligned with the divider outputs
    logic [SBW-1:0] sb_reg [NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            for (int i = 0; i < NW; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else
        begin
            s1_reg    <= sb_next;
            sb_reg[0] <= s1_reg;
            for (int i = 1; i < NW; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    // unpack side data
    logic                 d_vld, d_zx, d_zy, d_okx, d_oky;
    logic [3:0]           d_sg;
    logic signed [CW-1:0] d_ox, d_oy, d_dx, d_dy;

    assign {d_vld, d_zx, d_zy, d_okx, d_oky, d_sg, d_ox, d_oy, d_dx, d_dy} = sb_reg[NW-1];

    // ---------------- P1: apply quotient signs
    logic                 p1_vld_reg;
    logic                 p1_zx_reg, p1_zy_reg, p1_okx_reg, p1_oky_reg;
    logic signed [CW-1:0] p1_ox_reg, p1_oy_reg, p1_dx_reg, p1_dy_reg;
    logic signed [TW-1:0] t00_reg, t01_reg, t10_reg, t11_reg;

    always_ff @(posedge clk)
    begin
        t00_reg <= d_sg[0] ? -$signed(TW'(q00)) : $signed(TW'(q00));
        t01_reg <= d_sg[1] ? -$signed(TW'(q01)) : $signed(TW'(q01));
        t10_reg <= d_sg[2] ? -$signed(TW'(q10)) : $signed(TW'(q10));
        t11_reg <= d_sg[3] ? -$signed(TW'(q11)) : $signed(TW'(q11));
        p1_zx_reg  <= d_zx;
        p1_zy_reg  <= d_zy;
        p1_okx_reg <= d_okx;
        p1_oky_reg <= d_oky;
        p1_ox_reg  <= d_ox;
        p1_oy_reg  <= d_oy;
        p1_dx_reg  <= d_dx;
        p1_dy_reg  <= d_dy;
    end

    // ---------------- P2: order each slab, parallel rays span everything
    logic                 p2_vld_reg, p2_okx_reg, p2_oky_reg;
    logic signed [CW-1:0] p2_ox_reg, p2_oy_reg, p2_dx_reg, p2_dy_reg;
    logic signed [TW-1:0] lox_reg, hix_reg, loy_reg, hiy_reg;

    always_ff @(posedge clk)
    begin
        if (p1_zx_reg)
        begin
            lox_reg <= T_NUNB;
            hix_reg <= T_UNB;
        end
        else if (t00_reg > t01_reg)
        begin
            lox_reg <= t01_reg;
            hix_reg <= t00_reg;
        end
        else
        begin
            lox_reg <= t00_reg;
            hix_reg <= t01_reg;
        end
        if (p1_zy_reg)
        begin
            loy_reg <= T_NUNB;
            hiy_reg <= T_UNB;
        end
        else if (t10_reg > t11_reg)
        begin
            loy_reg <= t11_reg;
            hiy_reg <= t10_reg;
        end
        else
        begin
            loy_reg <= t10_reg;
            hiy_reg <= t11_reg;
        end
        p2_okx_reg <= p1_okx_reg;
        p2_oky_reg <= p1_oky_reg;
        p2_ox_reg  <= p1_ox_reg;
        p2_oy_reg  <= p1_oy_reg;
        p2_dx_reg  <= p1_dx_reg;
        p2_dy_reg  <= p1_dy_reg;
    end

    // ---------------- P3: interval intersection, hit decision, normal
    logic                 p3_hit_next;
    logic signed [TW-1:0] tn_next, tf_next;
    rbsi_pkg::norm_t      code_next;

    logic                 p3_vld_reg, p3_hit_reg;
    logic signed [TW-1:0] tn_reg, tf_reg;
    rbsi_pkg::norm_t      p3_code_reg;
    logic signed [CW-1:0] p3_ox_reg, p3_oy_reg, p3_dx_reg, p3_dy_reg;

    always_comb
    begin
        tn_next = (lox_reg > loy_reg) ? lox_reg : loy_reg;
        tf_next = (hix_reg < hiy_reg) ? hix_reg : hiy_reg;
        // exit time negative when either slab exit is negative
        p3_hit_next = p2_okx_reg && p2_oky_reg &&
                      !(lox_reg > hiy_reg) && !(loy_reg > hix_reg) &&
                      !hix_reg[TW-1] && !hiy_reg[TW-1];
        if (lox_reg > loy_reg)
            code_next = p2_dx_reg[CW-1] ? rbsi_pkg::NORM_PX : rbsi_pkg::NORM_NX;
        else if (lox_reg < loy_reg)
            code_next = p2_dy_reg[CW-1] ? rbsi_pkg::NORM_PY : rbsi_pkg::NORM_NY;
        else
            code_next = rbsi_pkg::NORM_NONE;
    end

    always_ff @(posedge clk)
    begin
        tn_reg      <= tn_next;
        tf_reg      <= tf_next;
        p3_hit_reg  <= p3_hit_next;
        p3_code_reg <= code_next;
        p3_ox_reg   <= p2_ox_reg;
        p3_oy_reg   <= p2_oy_reg;
        p3_dx_reg   <= p2_dx_reg;
        p3_dy_reg   <= p2_dy_reg;
    end

    // ---------------- P4: saturate times, zero the fields of a miss
    logic signed [CW-1:0] tns_next, tfs_next;

    logic                 p4_vld_reg, p4_hit_reg;
    logic signed [CW-1:0] tns_reg, tfs_reg;
    rbsi_pkg::norm_t      p4_code_reg;
    logic signed [CW-1:0] p4_ox_reg, p4_oy_reg, p4_dx_reg, p4_dy_reg;

    always_comb
    begin
        if (tn_reg > T_CMAX)
            tns_next = T_CMAX[CW-1:0];
        else if (tn_reg < T_CMIN)
            tns_next = T_CMIN[CW-1:0];
        else
            tns_next = tn_reg[CW-1:0];
        if (tf_reg > T_CMAX)
            tfs_next = T_CMAX[CW-1:0];
        else if (tf_reg < T_CMIN)
            tfs_next = T_CMIN[CW-1:0];
        else
            tfs_next = tf_reg[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        tns_reg     <= p3_hit_reg ? tns_next : '0;
        tfs_reg     <= p3_hit_reg ? tfs_next : '0;
        p4_code_reg <= p3_hit_reg ? p3_code_reg : rbsi_pkg::NORM_NONE;
        p4_hit_reg  <= p3_hit_reg;
        p4_ox_reg   <= p3_ox_reg;
        p4_oy_reg   <= p3_oy_reg;
        p4_dx_reg   <= p3_dx_reg;
        p4_dy_reg   <= p3_dy_reg;
    end

    // ---------------- P5/P6: contact point, two stages per axis
    rbsi_contact #(.CW(CW), .FB(FRAC_BITS)) u_cx
    (
        .clk    (clk),
        .keep   (p4_hit_reg),
        .origin (p4_ox_reg),
        .dir    (p4_dx_reg),
        .tval   (tns_reg),
        .coord  (contact_x)
    );

    rbsi_contact #(.CW(CW), .FB(FRAC_BITS)) u_cy
    (
        .clk    (clk),
        .keep   (p4_hit_reg),
        .origin (p4_oy_reg),
        .dir    (p4_dy_reg),
        .tval   (tns_reg),
        .coord  (contact_y)
    );

    logic                 p5_vld_reg, p5_hit_reg;
    logic signed [CW-1:0] p5_tn_reg, p5_tf_reg;
    rbsi_pkg::norm_t      p5_code_reg;
    logic                 out_vld_reg, out_hit_reg;
    logic signed [CW-1:0] out_tn_reg, out_tf_reg;
    rbsi_pkg::norm_t      out_code_reg;

    always_ff @(posedge clk)
    begin
        p5_hit_reg   <= p4_hit_reg;
        p5_tn_reg    <= tns_reg;
        p5_tf_reg    <= tfs_reg;
        p5_code_reg  <= p4_code_reg;
        out_hit_reg  <= p5_hit_reg;
        out_tn_reg   <= p5_tn_reg;
        out_tf_reg   <= p5_tf_reg;
        out_code_reg <= p5_code_reg;
    end

    // valid bits of the post-divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg  <= d_vld;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= p3_vld_reg;
            p5_vld_reg  <= p4_vld_reg;
            out_vld_reg <= p5_vld_reg;
        end
    end

    assign done        = out_vld_reg;
    assign hit         = out_hit_reg;
    assign time_near   = out_tn_reg;
    assign time_far    = out_tf_reg;
    assign normal_code = out_code_reg;

    // ---------------- assertions
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##LAT done)
        else $error("item did not complete at the pipeline latency");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (time_near == '0 && time_far == '0 &&
                            contact_x == '0 && contact_y == '0 &&
                            normal_code == rbsi_pkg::NORM_NONE))
        else $error("miss result carries nonzero fields");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (time_near <= time_far))
        else $error("entry time after exit time on a hit");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_code <= rbsi_pkg::NORM_NY))
        else $error("normal code out of range");

endmodule

@@ design/rbsi_div.sv @@
// ----------------------------------------------------------------------------
// rbsi_div
// Unsigned restoring divider, one quotient bit per register stage.
// Accepts a new operand pair every cycle.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] den_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [NW-1:0] num_in;
            logic [NW-1:0] quo_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   trial;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = num;
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign num_in = num_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign trial = {rem_in, num_in[NW-1]};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                num_reg[k] <= num_in << 1;
                quo_reg[k] <= {quo_in[NW-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    endgenerate

    assign quo = quo_reg[NW-1];

endmodule

@@ design/rbsi_contact.sv @@
// ----------------------------------------------------------------------------
// rbsi_contact
// Contact coordinate origin + dir * t, Q format, saturated. Two stages:
// multiply magnitudes, then shift, sign, add and clamp; zero when keep is low.
// ----------------------------------------------------------------------------
module rbsi_contact #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 clk,
    input  logic                 keep,
    input  logic signed [CW-1:0] origin,
    input  logic signed [CW-1:0] dir,
    input  logic signed [CW-1:0] tval,
    output logic signed [CW-1:0] coord
);

    localparam int PW = 2 * CW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] S_MAX = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

    logic [CW-1:0]        dmag;
    logic [CW-1:0]        tmag;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;
    logic                 keep_reg;
    logic signed [CW-1:0] org_reg;
    logic signed [SW-1:0] osx;
    logic signed [SW-1:0] psx;
    logic signed [SW-1:0] sum;
    logic signed [CW-1:0] sat_val;
    logic signed [CW-1:0] coord_reg;

    assign dmag = dir[CW-1]  ? (~dir + CW'(1))  : dir;
    assign tmag = tval[CW-1] ? (~tval + CW'(1)) : tval;

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(dmag) * PW'(tmag);
        neg_reg  <= dir[CW-1] ^ tval[CW-1];
        keep_reg <= keep;
        org_reg  <= origin;
    end

    always_comb
    begin
        osx = SW'(org_reg);
        psx = $signed({2'b00, prod_reg >> FB});
        sum = neg_reg ? (osx - psx) : (osx + psx);
        if (sum > S_MAX)
            sat_val = S_MAX[CW-1:0];
        else if (sum < S_MIN)
            sat_val = S_MIN[CW-1:0];
        else
            sat_val = sum[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= keep_reg ? sat_val : '0;
    end

    assign coord = coord_reg;

endmodule
